FILE: src/jsef_pkg.sv
package jsef_pkg;

    // Mode codes of an input item; codes above MODE_OBJ_VALUE act as MODE_VALUE
    localparam logic [2:0] MODE_VALUE     = 3'd0;
    localparam logic [2:0] MODE_PAIR_NAME = 3'd1;
    localparam logic [2:0] MODE_PAIR_VAL  = 3'd2;
    localparam logic [2:0] MODE_OBJ_NAME  = 3'd3;
    localparam logic [2:0] MODE_OBJ_VALUE = 3'd4;

    // Character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    // Output slots of one item, in emission order
    localparam int NUM_SLOTS = 10;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    localparam logic [SLOT_W-1:0] S_BRACE_OPEN  = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] S_QUOTE_OPEN  = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] S_AT          = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] S_ESC         = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] S_CHR         = SLOT_W'(4);
    localparam logic [SLOT_W-1:0] S_QUOTE_CLOSE = SLOT_W'(5);
    localparam logic [SLOT_W-1:0] S_SP_PRE      = SLOT_W'(6);
    localparam logic [SLOT_W-1:0] S_COLON       = SLOT_W'(7);
    localparam logic [SLOT_W-1:0] S_SP_POST     = SLOT_W'(8);
    localparam logic [SLOT_W-1:0] S_BRACE_CLOSE = SLOT_W'(9);

    // Command queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [NUM_SLOTS-1:0] t_slot_mask;

    // One classified item: which slots to emit and the byte for the char slot
    typedef struct packed {
        t_slot_mask mask;
        logic [7:0] chr;
    } t_cmd;

    // Byte that a slot puts out
    function automatic logic [7:0] slot_byte(input logic [SLOT_W-1:0] slot,
                                             input logic [7:0] chr);
        logic [7:0] b;
        b = chr;
        unique case (slot)
            S_BRACE_OPEN:  b = CH_LBRACE;
            S_QUOTE_OPEN:  b = CH_QUOTE;
            S_AT:          b = CH_AT;
            S_ESC:         b = CH_BSLASH;
            S_CHR:         b = chr;
            S_QUOTE_CLOSE: b = CH_QUOTE;
            S_SP_PRE:      b = CH_SPACE;
            S_COLON:       b = CH_COLON;
            S_SP_POST:     b = CH_SPACE;
            S_BRACE_CLOSE: b = CH_RBRACE;
            default:       b = chr;
        endcase
        return b;
    endfunction

endpackage

FILE: src/jsef_ifs.sv
// Input channel: one string byte with its tags
interface jsef_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       is_first;
    logic       is_last;
    logic       is_empty;
    logic       add_at_prefix;
    logic [2:0] mode;

    modport source (output valid, char_byte, is_first, is_last, is_empty,
                    add_at_prefix, mode, input ready);
    modport sink   (input valid, char_byte, is_first, is_last, is_empty,
                    add_at_prefix, mode, output ready);
endinterface

// Output channel: one byte of JSON text
interface jsef_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, out_byte, run_last, input ready);
    modport sink   (input valid, out_byte, run_last, output ready);
endinterface

FILE: src/json_string_escape_framer.sv
// Channel  Dir  Payload                                                 Transfer
// i_in     in   char_byte, is_first, is_last, is_empty, add_at_prefix,  valid && ready
//               mode
// o_out    out  out_byte, run_last                                      valid && ready
// cfg      in   i_cfg_wr_data (pair_spacing)                            i_cfg_wr_en
//
// Each item produces 1 to 9 output bytes; the back end puts out one byte per
// cycle while the output is not stalled.
// A two-entry command queue sits between classifier and emitter; input keeps
// flowing while the output stalls until the queue fills.
// Synchronous active-low reset clears the queue, the emitter and pair_spacing.
module json_string_escape_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jsef_in_if.sink     i_in,
    jsef_out_if.source  o_out,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data
);
    import jsef_pkg::*;

    logic   r_pair_spacing;
    logic   push_valid;
    logic   push_ready;
    t_cmd   push_cmd;
    logic   pop_valid;
    logic   pop_ready;
    t_cmd   pop_cmd;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_spacing <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_pair_spacing <= i_cfg_wr_data;
        end
    end

    jsef_front u_front (
        .i_in           (i_in),
        .i_pair_spacing (r_pair_spacing),
        .o_push_valid   (push_valid),
        .o_push_cmd     (push_cmd),
        .i_push_ready   (push_ready)
    );

    jsef_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop_ready  (pop_ready)
    );

    jsef_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_cmd   (pop_cmd),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

FILE: src/jsef_front.sv
module jsef_front (
    jsef_in_if.sink           i_in,
    input  logic              i_pair_spacing,
    output logic              o_push_valid,
    output jsef_pkg::t_cmd    o_push_cmd,
    input  logic              i_push_ready
);
    import jsef_pkg::*;

    logic [2:0] mode_n;
    logic       is_name;
    logic       need_esc;
    logic [7:0] esc_chr;
    t_slot_mask open_mask;
    t_slot_mask close_mask;
    t_slot_mask mask;

    // Handshake passes straight to the queue
    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

    // Unused modes fold onto plain value
    assign mode_n  = (i_in.mode > MODE_OBJ_VALUE) ? MODE_VALUE : i_in.mode;
    assign is_name = (mode_n == MODE_PAIR_NAME) || (mode_n == MODE_OBJ_NAME);

    // Escape classification
    always_comb begin
        need_esc = 1'b1;
        esc_chr  = i_in.char_byte;
        unique case (i_in.char_byte)
            CH_QUOTE:  esc_chr = CH_QUOTE;
            CH_BSLASH: esc_chr = CH_BSLASH;
            CH_BS:     esc_chr = CH_LOW_B;
            CH_FF:     esc_chr = CH_LOW_F;
            CH_LF:     esc_chr = CH_LOW_N;
            CH_CR:     esc_chr = CH_LOW_R;
            CH_TAB:    esc_chr = CH_LOW_T;
            default:   need_esc = 1'b0;
        endcase
    end

    // Framing slots
    always_comb begin
        open_mask  = '0;
        close_mask = '0;
        open_mask[S_BRACE_OPEN]   = (mode_n == MODE_OBJ_NAME);
        open_mask[S_QUOTE_OPEN]   = 1'b1;
        close_mask[S_QUOTE_CLOSE] = 1'b1;
        close_mask[S_SP_PRE]      = is_name && i_pair_spacing;
        close_mask[S_COLON]       = is_name;
        close_mask[S_SP_POST]     = is_name && i_pair_spacing;
        close_mask[S_BRACE_CLOSE] = (mode_n == MODE_OBJ_VALUE);
    end

    // Full slot set of the item
    always_comb begin
        mask = '0;
        if (i_in.is_empty) begin
            mask = open_mask | close_mask;
        end else begin
            if (i_in.is_first) begin
                mask = mask | open_mask;
                mask[S_AT] = i_in.add_at_prefix && (i_in.char_byte != CH_AT);
            end
            mask[S_ESC] = need_esc;
            mask[S_CHR] = 1'b1;
            if (i_in.is_last) begin
                mask = mask | close_mask;
            end
        end
    end

    assign o_push_cmd.mask = mask;
    assign o_push_cmd.chr  = esc_chr;

endmodule

FILE: src/jsef_queue.sv
module jsef_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  jsef_pkg::t_cmd    i_push_cmd,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output jsef_pkg::t_cmd    o_pop_cmd,
    input  logic              i_pop_ready
);
    import jsef_pkg::*;

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count, n_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

FILE: src/jsef_back.sv
module jsef_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    input  jsef_pkg::t_cmd    i_pop_cmd,
    output logic              o_pop_ready,
    jsef_out_if.source        o_out
);
    import jsef_pkg::*;

    logic               r_cur_valid, n_cur_valid;
    t_slot_mask         r_mask, n_mask;
    logic [7:0]         r_chr, n_chr;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_byte, n_out_byte;
    logic               r_out_last, n_out_last;

    logic               out_free;
    logic               step;
    logic               done;
    t_slot_mask         sel;
    t_slot_mask         mask_rest;
    logic [7:0]         sel_byte;

    assign out_free  = !r_out_valid || o_out.ready;
    assign step      = r_cur_valid && out_free;
    assign sel       = r_mask & (~r_mask + 1'b1);
    assign mask_rest = r_mask & ~sel;
    assign done      = step && (mask_rest == '0);

    // Next command loads when idle or finishing the current one
    assign o_pop_ready = !r_cur_valid || done;

    // Byte of the lowest pending slot
    always_comb begin
        sel_byte = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (sel[i]) begin
                sel_byte = sel_byte | slot_byte(SLOT_W'(i), r_chr);
            end
        end
    end

    // Sequencer and output register
    always_comb begin
        n_cur_valid = r_cur_valid;
        n_mask      = r_mask;
        n_chr       = r_chr;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (step) begin
            n_out_valid = 1'b1;
            n_out_byte  = sel_byte;
            n_out_last  = done;
            n_mask      = mask_rest;
            if (done) begin
                n_cur_valid = 1'b0;
            end
        end
        if (i_pop_valid && o_pop_ready) begin
            n_cur_valid = 1'b1;
            n_mask      = i_pop_cmd.mask;
            n_chr       = i_pop_cmd.chr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_valid <= n_cur_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask     <= n_mask;
        r_chr      <= n_chr;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.run_last = r_out_last;

`ifndef SYNTH
    // A held command always has a slot left to emit
    a_cur_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_mask != '0))
        else $error("active command with empty slot mask");

    // Finishing a command marks the byte as the last of its item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (r_out_valid && r_out_last))
        else $error("last byte of item not flagged");

    // A step that does not finish leaves work for the next cycle
    a_step_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !done) |=> r_cur_valid)
        else $error("command dropped before its last byte");

    // Exactly one slot chosen while busy
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> $onehot(sel))
        else $error("slot select not one-hot");
`endif

endmodule

FILE: sim/json_string_escape_framer_tb.sv
module json_string_escape_framer_tb;
    import jsef_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PER_SET = 32;

    // Mode codes past the last named one; the block treats them as plain values
    localparam logic [2:0] MODE_SPARE_0 = MODE_OBJ_VALUE + 3'd1;
    localparam logic [2:0] MODE_SPARE_1 = MODE_OBJ_VALUE + 3'd2;
    localparam logic [2:0] MODE_SPARE_2 = MODE_OBJ_VALUE + 3'd3;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_first;
        logic       is_last;
        logic       is_empty;
        logic       add_at_prefix;
        logic [2:0] mode;
    } t_char_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_json_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    jsef_in_if  in_ch ();
    jsef_out_if out_ch ();

    json_string_escape_framer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .o_out         (out_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    t_char_item pending_chars[$];
    t_json_byte expected_json[$];
    logic       spacing_shadow = 1'b0;
    int         mismatches     = 0;

    // Sender pacing
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver pacing
    logic [7:0] rdy_pat   = 8'hFF;
    logic [5:0] pat_age   = '0;
    int         hold_left = 0;
    int         rx_seen   = 0;

    int idle_cycles = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    // Expected JSON text for one accepted string byte
    function automatic void encode_char_item(input t_char_item it);
        logic [7:0] seq[$];
        logic [2:0] md;
        md = (it.mode > MODE_OBJ_VALUE) ? MODE_VALUE : it.mode;
        // opening quote, brace for an object name
        if (it.is_empty || it.is_first) begin
            if (md == MODE_OBJ_NAME) seq.push_back(CH_LBRACE);
            seq.push_back(CH_QUOTE);
        end
        // content; an empty string has none and never takes the '@'
        if (!it.is_empty) begin
            if (it.is_first && it.add_at_prefix && it.char_byte != CH_AT)
                seq.push_back(CH_AT);
            case (it.char_byte)
                CH_QUOTE, CH_BSLASH: begin
                    seq.push_back(CH_BSLASH);
                    seq.push_back(it.char_byte);
                end
                CH_BS: begin
                    seq.push_back(CH_BSLASH);
                    seq.push_back(CH_LOW_B);
                end
                CH_FF: begin
                    seq.push_back(CH_BSLASH);
                    seq.push_back(CH_LOW_F);
                end
                CH_LF: begin
                    seq.push_back(CH_BSLASH);
                    seq.push_back(CH_LOW_N);
                end
                CH_CR: begin
                    seq.push_back(CH_BSLASH);
                    seq.push_back(CH_LOW_R);
                end
                CH_TAB: begin
                    seq.push_back(CH_BSLASH);
                    seq.push_back(CH_LOW_T);
                end
                default: seq.push_back(it.char_byte);
            endcase
        end
        // closing quote, then colon (spaced when pair spacing is on) after names or brace after object value
        if (it.is_empty || it.is_last) begin
            seq.push_back(CH_QUOTE);
            if (md == MODE_PAIR_NAME || md == MODE_OBJ_NAME) begin
                if (spacing_shadow) seq.push_back(CH_SPACE);
                seq.push_back(CH_COLON);
                if (spacing_shadow) seq.push_back(CH_SPACE);
            end else if (md == MODE_OBJ_VALUE) begin
                seq.push_back(CH_RBRACE);
            end
        end
        foreach (seq[k])
            expected_json.push_back('{out_byte: seq[k], run_last: (k == seq.size() - 1)});
    endfunction

    // Byte picker that leans toward the escaped and framing characters
    function automatic logic [7:0] pick_char_byte();
        logic [7:0] hot[10];
        hot = '{CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB, CH_AT,
                8'h00, 8'hFF};
        if ($urandom_range(0, 99) < 35) return hot[$urandom_range(0, 9)];
        return 8'($urandom);
    endfunction

    task automatic add_item(input logic [7:0] c, input logic f, input logic l,
                            input logic e, input logic a, input logic [2:0] m);
        pending_chars.push_back('{char_byte: c, is_first: f, is_last: l, is_empty: e,
                                  add_at_prefix: a, mode: m});
    endtask

    // Mostly whole strings with random content, plus empties and loose noise
    task automatic add_random_strings(input int count);
        int         made;
        int         len;
        int         roll;
        logic [2:0] md;
        logic       at;
        made = 0;
        while (made < count) begin
            roll = $urandom_range(0, 99);
            md   = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            at   = 1'($urandom);
            if (roll < 12) begin
                add_item(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                         1'($urandom), 3'($urandom));
                made++;
            end else if (roll < 22) begin
                add_item(8'($urandom), 1'($urandom), 1'($urandom), 1'b1, at, md);
                made++;
            end else begin
                len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
                for (int k = 0; k < len; k++)
                    add_item(pick_char_byte(), k == 0, k == len - 1, 1'b0, at, md);
                made += len;
            end
        end
    endtask

    task automatic write_spacing(input logic value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        spacing_shadow = value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Wait until every queued byte went in and all its text came back
    task automatic drain_and_settle();
        while (pending_chars.size() != 0 || in_ch.valid || expected_json.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        t_char_item it;
        logic       nxt_valid;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_chars.size() != 0) begin
                it = pending_chars.pop_front();
                in_ch.char_byte     <= it.char_byte;
                in_ch.is_first      <= it.is_first;
                in_ch.is_last       <= it.is_last;
                in_ch.is_empty      <= it.is_empty;
                in_ch.add_at_prefix <= it.add_at_prefix;
                in_ch.mode          <= it.mode;
                nxt_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            in_ch.valid <= nxt_valid;
        end
    end

    // Receiver: rotating stall pattern, with a long hold-off after the 60th and the 300th byte taken
    always @(posedge i_clk) begin
        logic took;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            took = out_ch.valid && out_ch.ready;
            if (took) rx_seen++;
            pat_age++;
            if (pat_age == 0) begin
                case ($urandom_range(0, 3))
                    0:       rdy_pat = 8'hFF;
                    1:       rdy_pat = 8'($urandom);
                    2:       rdy_pat = ~(8'h01 << $urandom_range(0, 7));
                    default: rdy_pat = 8'h11;
                endcase
            end
            if (took && (rx_seen == 60 || rx_seen == 300)) begin
                hold_left = LONG_HOLD;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= rdy_pat[0];
                rdy_pat = {rdy_pat[0], rdy_pat[7:1]};
            end
        end
    end

    // Monitor: predict on each input transfer, then check the output transfer
    always @(posedge i_clk) begin
        t_json_byte want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                encode_char_item('{char_byte: in_ch.char_byte, is_first: in_ch.is_first,
                                   is_last: in_ch.is_last, is_empty: in_ch.is_empty,
                                   add_at_prefix: in_ch.add_at_prefix, mode: in_ch.mode});
            if (out_ch.valid && out_ch.ready) begin
                if (expected_json.size() == 0) begin
                    $error("unexpected output transfer: out_byte %h run_last %b",
                           out_ch.out_byte, out_ch.run_last);
                    mismatches++;
                end else begin
                    want = expected_json.pop_front();
                    if (out_ch.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, actual %h", want.out_byte,
                               out_ch.out_byte);
                        mismatches++;
                    end
                    if (out_ch.run_last !== want.run_last) begin
                        $error("run_last: expected %b, actual %b", want.run_last,
                               out_ch.run_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_wr_data       = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.char_byte     = '0;
        in_ch.is_first      = 1'b0;
        in_ch.is_last       = 1'b0;
        in_ch.is_empty      = 1'b0;
        in_ch.add_at_prefix = 1'b0;
        in_ch.mode          = MODE_VALUE;
        out_ch.ready        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings with spacing at its reset value
        add_item(8'h41, 1'b1, 1'b1, 1'b0, 1'b0, MODE_VALUE);
        add_item(CH_AT, 1'b1, 1'b0, 1'b0, 1'b1, MODE_PAIR_NAME);   // '@' already there
        add_item(CH_QUOTE, 1'b0, 1'b0, 1'b0, 1'b1, MODE_PAIR_NAME);
        add_item(CH_BSLASH, 1'b0, 1'b1, 1'b0, 1'b0, MODE_PAIR_NAME);
        add_item(8'h61, 1'b1, 1'b0, 1'b0, 1'b1, MODE_PAIR_VAL);     // gets '@'
        add_item(CH_BS, 1'b0, 1'b0, 1'b0, 1'b0, MODE_PAIR_VAL);
        add_item(CH_FF, 1'b0, 1'b0, 1'b0, 1'b0, MODE_PAIR_VAL);
        add_item(CH_LF, 1'b0, 1'b0, 1'b0, 1'b0, MODE_PAIR_VAL);
        add_item(CH_CR, 1'b0, 1'b0, 1'b0, 1'b0, MODE_PAIR_VAL);
        add_item(CH_TAB, 1'b0, 1'b1, 1'b0, 1'b0, MODE_PAIR_VAL);
        add_item(8'h00, 1'b1, 1'b0, 1'b0, 1'b0, MODE_OBJ_NAME);
        add_item(8'h1F, 1'b0, 1'b0, 1'b0, 1'b1, MODE_OBJ_NAME);     // raw control byte
        add_item(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, MODE_OBJ_NAME);
        add_item(8'h7F, 1'b1, 1'b1, 1'b0, 1'b1, MODE_OBJ_VALUE);
        // empty strings: tags and byte are junk, no '@'
        add_item(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, MODE_VALUE);
        add_item(CH_AT, 1'b0, 1'b0, 1'b1, 1'b1, MODE_PAIR_NAME);
        add_item(CH_QUOTE, 1'b1, 1'b0, 1'b1, 1'b0, MODE_PAIR_VAL);
        add_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, MODE_OBJ_NAME);
        add_item(CH_LF, 1'b0, 1'b0, 1'b1, 1'b0, MODE_OBJ_VALUE);
        // spare mode codes act as plain values
        add_item(8'h31, 1'b1, 1'b1, 1'b0, 1'b1, MODE_SPARE_0);
        add_item(CH_TAB, 1'b1, 1'b0, 1'b0, 1'b0, MODE_SPARE_1);
        add_item(8'h32, 1'b0, 1'b1, 1'b0, 1'b0, MODE_SPARE_2);
        drain_and_settle();

        write_spacing(1'b1);
        add_random_strings(RANDOM_PER_SET);
        drain_and_settle();

        write_spacing(1'b0);
        add_random_strings(RANDOM_PER_SET);
        drain_and_settle();

        write_spacing(1'b1);
        add_random_strings(RANDOM_PER_SET);
        drain_and_settle();

        if (expected_json.size() != 0) begin
            $error("%0d expected output bytes never arrived", expected_json.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
